### hdl/hsb2rgb_pkg.sv
// ----------------------------------------------------------------------------
// HSB to RGB package
// Shared types and constants of the HSB to RGB color converter.
// ----------------------------------------------------------------------------
package hsb2rgb_pkg;

   // Width of every input component field (signed fixed point).
   localparam int IN_WIDTH = 18;

   // Width of one color channel and of the packed result.
   localparam int CH_WIDTH    = 8;
   localparam int COLOR_WIDTH = 32;

   // The alpha byte of every result is fully opaque.
   localparam logic [CH_WIDTH-1:0] ALPHA_BYTE = 8'hFF;

   // Cycles from an accepted request beat to its response beat.
   localparam int LATENCY = 4;

   // Hue sector, 0..5 after scaling the hue by six.
   typedef logic [2:0] sector_type;

   localparam sector_type SECT_RED_TO_YELLOW    = 3'd0;
   localparam sector_type SECT_YELLOW_TO_GREEN  = 3'd1;
   localparam sector_type SECT_GREEN_TO_CYAN    = 3'd2;
   localparam sector_type SECT_CYAN_TO_BLUE     = 3'd3;
   localparam sector_type SECT_BLUE_TO_MAGENTA  = 3'd4;
   localparam sector_type SECT_MAGENTA_TO_RED   = 3'd5;

endpackage

### hdl/hsb_to_rgb_converter_top.sv
// ----------------------------------------------------------------------------
// HSB to RGB color converter
// Converts hue, saturation and brightness to a packed opaque ARGB word.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel: drive req_hue, req_saturation and req_brightness
//    (signed fixed point, 1 << FRAC_BITS stands for 1.0) and raise start.
//    A beat is taken at every rising edge where start is high and busy is
//    low. busy is never raised, so one beat can be taken on every cycle.
//  - Response channel: rsp_strobe is high for exactly one cycle with the
//    result on rsp_packed_color (0xFF, red, green, blue from the top byte).
//    The receiver cannot hold responses off; it must take each one.
//  - Throughput is one beat per cycle. The latency from the accepting edge
//    to the edge that takes the response is set by the four-stage pipeline:
//    clamp and hue scaling, the s*f multiplier, the p/q/t products, then
//    channel rounding and sector ordering.
//  - A synchronous reset clears all stage valid bits, so beats still in
//    flight are dropped and no response comes out for them.
//  - Components are clamped to 0..1.0; a hue of exactly 1.0 wraps to 0.
// ----------------------------------------------------------------------------
module hsb_to_rgb_converter_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   output logic                                      busy,
   input  logic signed [hsb2rgb_pkg::IN_WIDTH-1:0]   req_hue,
   input  logic signed [hsb2rgb_pkg::IN_WIDTH-1:0]   req_saturation,
   input  logic signed [hsb2rgb_pkg::IN_WIDTH-1:0]   req_brightness,
   output logic                                      rsp_strobe,
   output logic        [hsb2rgb_pkg::COLOR_WIDTH-1:0] rsp_packed_color
);

   localparam int IN_W  = hsb2rgb_pkg::IN_WIDTH;
   localparam int CH_W  = hsb2rgb_pkg::CH_WIDTH;
   // Unsigned width that holds 0..1.0 inclusive.
   localparam int ONE_W = FRAC_BITS + 1;
   // Width used to compare the input magnitude with 1.0.
   localparam int CMP_W = (FRAC_BITS + 2 > IN_W) ? FRAC_BITS + 2 : IN_W;
   // Hue times six needs three more bits than the fraction.
   localparam int HS_W  = FRAC_BITS + 3;
   // Product of two values in 0..1.0, at most 1.0 in Q(2*FRAC_BITS).
   localparam int X_W   = 2 * FRAC_BITS + 1;
   // Product times 255 plus the rounding half.
   localparam int ACC_W = X_W + CH_W;

   localparam logic [ONE_W-1:0] ONE      = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (2 * FRAC_BITS - 1);

   // The pipeline never stalls, so a beat can always be taken.
   assign busy = 1'b0;

   // Negative values go to zero, values above 1.0 go to 1.0.
   function automatic logic [ONE_W-1:0] clamp_value(input logic [IN_W-1:0] raw);
      logic [CMP_W-1:0] mag;
      logic [CMP_W-1:0] one_ext;
      mag     = CMP_W'(raw[IN_W-2:0]);
      one_ext = CMP_W'(ONE);
      if (raw[IN_W-1]) begin
         return '0;
      end else if (mag > one_ext) begin
         return ONE;
      end else begin
         return ONE_W'(mag);
      end
   endfunction

   // Round x * 255 half up to a byte; x never exceeds 1.0, so no saturation.
   function automatic logic [CH_W-1:0] to_byte(input logic [X_W-1:0] x);
      logic [ACC_W-1:0] acc;
      acc = {x, {CH_W{1'b0}}} - ACC_W'(x) + HALF_LSB;
      return acc[2*FRAC_BITS +: CH_W];
   endfunction

   // -------------------------------------------------------------------------
   // Stage 1: clamp the inputs, wrap a full-circle hue and scale it by six.
   // -------------------------------------------------------------------------
   logic                    s1_valid_ff;
   hsb2rgb_pkg::sector_type s1_sector_ff, s1_sector_in;
   logic [FRAC_BITS-1:0]    s1_f_ff, s1_f_in;
   logic [ONE_W-1:0]        s1_s_ff, s1_s_in;
   logic [ONE_W-1:0]        s1_v_ff, s1_v_in;

   logic [ONE_W-1:0]        hue_clamped;
   logic [FRAC_BITS-1:0]    hue_frac;
   logic [HS_W-1:0]         hue_x6;

   always_comb begin
      hue_clamped = clamp_value(req_hue);
      // After the wrap the hue is strictly below 1.0 and fits the fraction.
      hue_frac    = (hue_clamped == ONE) ? '0 : hue_clamped[FRAC_BITS-1:0];
      hue_x6      = HS_W'({hue_frac, 2'b00}) + HS_W'({hue_frac, 1'b0});
      s1_sector_in = hue_x6[HS_W-1:FRAC_BITS];
      s1_f_in      = hue_x6[FRAC_BITS-1:0];
      s1_s_in      = clamp_value(req_saturation);
      s1_v_in      = clamp_value(req_brightness);
   end

   // -------------------------------------------------------------------------
   // Stage 2: sf = s * f, truncated back to the fraction format.
   // -------------------------------------------------------------------------
   logic                    s2_valid_ff;
   hsb2rgb_pkg::sector_type s2_sector_ff;
   logic [ONE_W-1:0]        s2_s_ff;
   logic [ONE_W-1:0]        s2_v_ff;
   logic [ONE_W-1:0]        s2_sf_ff, s2_sf_in;
   logic [ONE_W+FRAC_BITS-1:0] sf_full;

   always_comb begin
      sf_full  = s1_s_ff * s1_f_ff;
      s2_sf_in = sf_full[ONE_W+FRAC_BITS-1:FRAC_BITS];
   end

   // -------------------------------------------------------------------------
   // Stage 3: p, q, t and v as exact products in Q(2*FRAC_BITS).
   // -------------------------------------------------------------------------
   logic                    s3_valid_ff;
   hsb2rgb_pkg::sector_type s3_sector_ff;
   logic [X_W-1:0]          s3_p_ff, s3_p_in;
   logic [X_W-1:0]          s3_q_ff, s3_q_in;
   logic [X_W-1:0]          s3_t_ff, s3_t_in;
   logic [X_W-1:0]          s3_vv_ff, s3_vv_in;

   logic [ONE_W-1:0]        factor_p;
   logic [ONE_W-1:0]        factor_q;
   logic [ONE_W-1:0]        factor_t;
   logic [2*ONE_W-1:0]      prod_p;
   logic [2*ONE_W-1:0]      prod_q;
   logic [2*ONE_W-1:0]      prod_t;

   always_comb begin
      factor_p = ONE - s2_s_ff;
      factor_q = ONE - s2_sf_ff;
      // sf never exceeds s, so this stays within 0..1.0.
      factor_t = ONE - s2_s_ff + s2_sf_ff;
      prod_p   = s2_v_ff * factor_p;
      prod_q   = s2_v_ff * factor_q;
      prod_t   = s2_v_ff * factor_t;
      s3_p_in  = prod_p[X_W-1:0];
      s3_q_in  = prod_q[X_W-1:0];
      s3_t_in  = prod_t[X_W-1:0];
      s3_vv_in = {s2_v_ff, {FRAC_BITS{1'b0}}};
   end

   // -------------------------------------------------------------------------
   // Stage 4: round each channel to a byte and order them by sector.
   // With zero saturation p, q and t all equal v, so every sector gives gray.
   // -------------------------------------------------------------------------
   logic                    rsp_strobe_ff;
   logic [hsb2rgb_pkg::COLOR_WIDTH-1:0] rsp_color_ff, rsp_color_in;

   logic [CH_W-1:0]         byte_p;
   logic [CH_W-1:0]         byte_q;
   logic [CH_W-1:0]         byte_t;
   logic [CH_W-1:0]         byte_v;
   logic [CH_W-1:0]         red;
   logic [CH_W-1:0]         green;
   logic [CH_W-1:0]         blue;

   always_comb begin
      byte_p = to_byte(s3_p_ff);
      byte_q = to_byte(s3_q_ff);
      byte_t = to_byte(s3_t_ff);
      byte_v = to_byte(s3_vv_ff);
      case (s3_sector_ff)
         hsb2rgb_pkg::SECT_RED_TO_YELLOW: begin
            red = byte_v; green = byte_t; blue = byte_p;
         end
         hsb2rgb_pkg::SECT_YELLOW_TO_GREEN: begin
            red = byte_q; green = byte_v; blue = byte_p;
         end
         hsb2rgb_pkg::SECT_GREEN_TO_CYAN: begin
            red = byte_p; green = byte_v; blue = byte_t;
         end
         hsb2rgb_pkg::SECT_CYAN_TO_BLUE: begin
            red = byte_p; green = byte_q; blue = byte_v;
         end
         hsb2rgb_pkg::SECT_BLUE_TO_MAGENTA: begin
            red = byte_t; green = byte_p; blue = byte_v;
         end
         default: begin
            // Magenta to red; the hue never yields a higher sector.
            red = byte_v; green = byte_p; blue = byte_q;
         end
      endcase
      rsp_color_in = {hsb2rgb_pkg::ALPHA_BYTE, red, green, blue};
   end

   // -------------------------------------------------------------------------
   // Valid bits travel with the data; only they are reset.
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s1_valid_ff   <= start && !busy;
         s2_valid_ff   <= s1_valid_ff;
         s3_valid_ff   <= s2_valid_ff;
         rsp_strobe_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_sector_ff <= s1_sector_in;
      s1_f_ff      <= s1_f_in;
      s1_s_ff      <= s1_s_in;
      s1_v_ff      <= s1_v_in;

      s2_sector_ff <= s1_sector_ff;
      s2_s_ff      <= s1_s_ff;
      s2_v_ff      <= s1_v_ff;
      s2_sf_ff     <= s2_sf_in;

      s3_sector_ff <= s2_sector_ff;
      s3_p_ff      <= s3_p_in;
      s3_q_ff      <= s3_q_in;
      s3_t_ff      <= s3_t_in;
      s3_vv_ff     <= s3_vv_in;

      rsp_color_ff <= rsp_color_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_packed_color = rsp_color_ff;

endmodule

### hdl/hsb2rgb_checker.sv
// ----------------------------------------------------------------------------
// HSB to RGB port checker
// Watches the converter's ports for beat timing and result properties.
// ----------------------------------------------------------------------------
module hsb2rgb_checker (
   input logic                                      clock,
   input logic                                      reset,
   input logic                                      start,
   input logic                                      busy,
   input logic [hsb2rgb_pkg::IN_WIDTH-1:0]          req_saturation,
   input logic [hsb2rgb_pkg::IN_WIDTH-1:0]          req_brightness,
   input logic                                      rsp_strobe,
   input logic [hsb2rgb_pkg::COLOR_WIDTH-1:0]       rsp_packed_color
);

   localparam int SIGN_BIT = hsb2rgb_pkg::IN_WIDTH - 1;

   // Every accepted request beat yields a response beat after the latency.
   a_beat_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(hsb2rgb_pkg::LATENCY) rsp_strobe)
      else $error("request beat produced no response beat");

   // No response beat appears without a request beat before it.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(start, hsb2rgb_pkg::LATENCY) &&
                      !$past(busy, hsb2rgb_pkg::LATENCY)))
      else $error("response beat without a request beat");

   // Alpha is always opaque.
   a_alpha: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_packed_color[31:24] == hsb2rgb_pkg::ALPHA_BYTE))
      else $error("alpha byte is not opaque");

   // Negative saturation clamps to zero and gives a gray response.
   a_gray: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_saturation[SIGN_BIT]) |->
         ##(hsb2rgb_pkg::LATENCY)
         (rsp_packed_color[23:16] == rsp_packed_color[15:8] &&
          rsp_packed_color[15:8]  == rsp_packed_color[7:0]))
      else $error("unsaturated beat did not give gray");

   // Negative brightness clamps to zero and gives black.
   a_black: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_brightness[SIGN_BIT]) |->
         ##(hsb2rgb_pkg::LATENCY) (rsp_packed_color[23:0] == 24'h000000))
      else $error("dark beat did not give black");

endmodule

bind hsb_to_rgb_converter_top hsb2rgb_checker u_hsb2rgb_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_saturation   (req_saturation),
   .req_brightness   (req_brightness),
   .rsp_strobe       (rsp_strobe),
   .rsp_packed_color (rsp_packed_color)
);

### verif/hsb_to_rgb_converter_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HSB to RGB converter testbench
// Sends hue, saturation and brightness beats to the converter and checks
// every packed color that comes back against a bit-exact local predictor or a hand-typed value.
// ----------------------------------------------------------------------------
module hsb_to_rgb_converter_top_test;

   // The converter is built with its default fixed point format, so 1.0 is
   // 1 << 16 on every component.
   localparam int FRAC_BITS = 16;
   localparam int ONE_Q     = 1 << FRAC_BITS;
   localparam longint unsigned UNITY = 64'd1 << FRAC_BITS;

   localparam int IN_W    = hsb2rgb_pkg::IN_WIDTH;
   localparam int CH_W    = hsb2rgb_pkg::CH_WIDTH;
   localparam int COLOR_W = hsb2rgb_pkg::COLOR_WIDTH;

   localparam int CLOCK_HALF      = 6;
   localparam int DIRECTED_COUNT  = 23;
   localparam int PHASE_COUNT     = 5;
   localparam int PHASE_BEATS     = 130;
   localparam int WATCHDOG_LIMIT  = 1000;

   // One row of the directed stimulus. Where has_known is set, the color is
   // typed in by hand; everything else is checked against the predictor.
   typedef struct {
      logic signed [IN_W-1:0] hue;
      logic signed [IN_W-1:0] sat;
      logic signed [IN_W-1:0] bright;
      bit                     has_known;
      logic [COLOR_W-1:0]     known;
   } directed_row_type;

   // One color still to come back from the pipeline.
   typedef struct {
      logic [COLOR_W-1:0] color;
      int                 beat;
   } pending_color_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               start = 1'b0;
   logic                               busy;
   logic signed [IN_W-1:0]             req_hue = '0;
   logic signed [IN_W-1:0]             req_saturation = '0;
   logic signed [IN_W-1:0]             req_brightness = '0;
   logic                               rsp_strobe;
   logic        [COLOR_W-1:0]          rsp_packed_color;

   pending_color_type pending_colors[$];
   int mismatch_count  = 0;
   int beats_sent      = 0;
   int colors_received = 0;
   int gray_beats      = 0;
   int clamped_fields  = 0;
   int quiet_cycles    = 0;
   int sector_hits [6] = '{default: 0};

   // Hand-checked corner cases come first: black, white, a gray that rounds
   // up, pure red and cyan at the exact sector starts, the hue wrap at 1.0,
   // and components far outside 0..1.0 on both sides. Then one beat in the
   // middle of each sector and a few odd mixes near the sector edges.
   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      '{0,       0,       0,       1, 32'hFF000000},
      '{0,       0,       ONE_Q,   1, 32'hFFFFFFFF},
      '{0,       0,       32768,   1, 32'hFF808080},
      '{0,       ONE_Q,   ONE_Q,   1, 32'hFFFF0000},
      '{ONE_Q,   ONE_Q,   ONE_Q,   1, 32'hFFFF0000},
      '{32768,   ONE_Q,   ONE_Q,   1, 32'hFF00FFFF},
      '{-131072, -131072, -131072, 1, 32'hFF000000},
      '{131071,  131071,  131071,  1, 32'hFFFF0000},
      '{12345,   -5,      131071,  1, 32'hFFFFFFFF},
      '{-1,      ONE_Q,   ONE_Q,   1, 32'hFFFF0000},
      '{40000,   ONE_Q,   0,       1, 32'hFF000000},
      '{5461,    ONE_Q,   ONE_Q,   0, 32'h0},
      '{16384,   ONE_Q,   ONE_Q,   0, 32'h0},
      '{27307,   ONE_Q,   ONE_Q,   0, 32'h0},
      '{38229,   ONE_Q,   ONE_Q,   0, 32'h0},
      '{49152,   ONE_Q,   ONE_Q,   0, 32'h0},
      '{60075,   ONE_Q,   ONE_Q,   0, 32'h0},
      '{65535,   32768,   ONE_Q,   0, 32'h0},
      '{10922,   ONE_Q,   49152,   0, 32'h0},
      '{10923,   40000,   49152,   0, 32'h0},
      '{21846,   1,       ONE_Q,   0, 32'h0},
      '{50000,   ONE_Q,   1,       0, 32'h0},
      '{-40000,  20000,   65535,   0, 32'h0}
   };

   // Idle percentage of the sender in each random phase. The receiver has
   // no way to stall, so only the sender side is varied.
   int idle_percent [PHASE_COUNT] = '{0, 72, 14, 72, 0};

   hsb_to_rgb_converter_top #(
      .FRAC_BITS(FRAC_BITS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_hue          (req_hue),
      .req_saturation   (req_saturation),
      .req_brightness   (req_brightness),
      .rsp_strobe       (rsp_strobe),
      .rsp_packed_color (rsp_packed_color)
   );

   always begin
      #(CLOCK_HALF) clock = 1'b1;
      #(CLOCK_HALF) clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // Negative components go to zero and anything above 1.0 saturates at 1.0.
   function automatic longint unsigned clamp_unit(input logic signed [IN_W-1:0] raw);
      longint wide;
      wide = raw;
      if (wide < 0)
         return 0;
      if (wide > longint'(UNITY))
         return UNITY;
      return longint'(wide);
   endfunction

   // Scales a Q(2*FRAC_BITS) value in 0..1.0 to a byte, rounding half up.
   function automatic logic [CH_W-1:0] round_to_byte(input longint unsigned prod);
      longint unsigned scaled;
      scaled = (prod * 255 + (64'd1 << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
      if (scaled > 255)
         scaled = 255;
      return scaled[CH_W-1:0];
   endfunction

   // Works out the packed ARGB word for one beat. The hue sector is handed
   // back too so the run can tell which sectors it reached.
   function automatic logic [COLOR_W-1:0] predict_color(
      input  logic signed [IN_W-1:0]  hue_in,
      input  logic signed [IN_W-1:0]  sat_in,
      input  logic signed [IN_W-1:0]  bright_in,
      output hsb2rgb_pkg::sector_type sect
   );
      longint unsigned h, s, v, scaled_hue, frac, s_frac;
      logic [CH_W-1:0] p, q, t, top, red, green, blue;
      h = clamp_unit(hue_in);
      s = clamp_unit(sat_in);
      v = clamp_unit(bright_in);
      // A hue of exactly 1.0 is the same color as a hue of zero.
      if (h >= UNITY)
         h = 0;
      scaled_hue = h * 6;
      sect       = hsb2rgb_pkg::sector_type'(scaled_hue >> FRAC_BITS);
      frac       = scaled_hue & (UNITY - 1);
      s_frac     = (s * frac) >> FRAC_BITS;
      top        = round_to_byte(v << FRAC_BITS);
      p          = round_to_byte(v * (UNITY - s));
      q          = round_to_byte(v * (UNITY - s_frac));
      t          = round_to_byte(v * (UNITY - s + s_frac));
      if (s == 0) begin
         red   = top;
         green = top;
         blue  = top;
      end else begin
         case (sect)
            hsb2rgb_pkg::SECT_RED_TO_YELLOW: begin
               red = top; green = t; blue = p;
            end
            hsb2rgb_pkg::SECT_YELLOW_TO_GREEN: begin
               red = q; green = top; blue = p;
            end
            hsb2rgb_pkg::SECT_GREEN_TO_CYAN: begin
               red = p; green = top; blue = t;
            end
            hsb2rgb_pkg::SECT_CYAN_TO_BLUE: begin
               red = p; green = q; blue = top;
            end
            hsb2rgb_pkg::SECT_BLUE_TO_MAGENTA: begin
               red = t; green = p; blue = top;
            end
            default: begin
               red = top; green = p; blue = q;
            end
         endcase
      end
      return {hsb2rgb_pkg::ALPHA_BYTE, red, green, blue};
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Mostly legal components, with a share of exact 0 and 1.0, values just
   // inside the limits, and full 18-bit noise so every bit toggles and both
   // clamps get hit.
   function automatic logic signed [IN_W-1:0] random_component();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         return IN_W'($urandom_range(0, ONE_Q));
      if (pick < 80)
         return ($urandom_range(0, 1) != 0) ? IN_W'(ONE_Q) : '0;
      if (pick < 86)
         return ($urandom_range(0, 1) != 0) ? IN_W'(ONE_Q - $urandom_range(0, 3))
                                            : IN_W'($urandom_range(0, 3));
      return IN_W'($urandom);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t ns: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // Presents one beat from the falling edge on and holds it until the
   // converter takes it. start is left high so back-to-back beats do not
   // drop it in between.
   task automatic send_request(
      input logic signed [IN_W-1:0] h,
      input logic signed [IN_W-1:0] s,
      input logic signed [IN_W-1:0] v,
      input bit                     has_known,
      input logic [COLOR_W-1:0]     known
   );
      pending_color_type       entry;
      hsb2rgb_pkg::sector_type sect;
      logic [COLOR_W-1:0]      predicted;
      req_hue        = h;
      req_saturation = s;
      req_brightness = v;
      start          = 1'b1;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      predicted   = predict_color(h, s, v, sect);
      entry.color = has_known ? known : predicted;
      entry.beat  = beats_sent;
      pending_colors.push_back(entry);
      beats_sent++;
      if (clamp_unit(s) == 0)
         gray_beats++;
      else
         sector_hits[sect]++;
      if (h < 0 || h > ONE_Q) clamped_fields++;
      if (s < 0 || s > ONE_Q) clamped_fields++;
      if (v < 0 || v > ONE_Q) clamped_fields++;
      @(negedge clock);
   endtask

   // One idle cycle. The request fields carry junk, which must be ignored
   // while start is low.
   task automatic idle_cycle();
      start          = 1'b0;
      req_hue        = IN_W'($urandom);
      req_saturation = IN_W'($urandom);
      req_brightness = IN_W'($urandom);
      @(negedge clock);
   endtask

   // Holds the sender back until every color in flight has come back.
   task automatic drain_pipeline();
      start = 1'b0;
      while (pending_colors.size() != 0)
         @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Response checking
   // ------------------------------------------------------------------------

   // Every strobe is a response beat that must match the oldest pending
   // color. The receiver cannot stall, so each strobe is taken on its edge.
   always @(posedge clock) begin : response_check
      pending_color_type head;
      if (!reset && rsp_strobe) begin
         colors_received++;
         if (pending_colors.size() == 0) begin
            report_mismatch($sformatf("unexpected response 0x%08h with nothing pending",
                                      rsp_packed_color));
         end else begin
            head = pending_colors.pop_front();
            if (rsp_packed_color !== head.color)
               report_mismatch($sformatf("beat %0d: packed_color 0x%08h, expected 0x%08h",
                                         head.beat, rsp_packed_color, head.color));
         end
      end
   end

   // The watchdog counts cycles in which neither a request nor a response
   // beat moves. A healthy run never gets close to the limit, even in the
   // phases where the sender idles most of the time.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("Timeout: no beat moved for %0d cycles, %0d colors pending.",
               WATCHDOG_LIMIT, pending_colors.size());
      $display("Simulation FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : main_sequence
      int phase;
      int n;
      // Reset is held from time zero and released on a falling edge,
      // so the converter sees it cleanly and only once.
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part, back to back with no gaps.
      foreach (directed_rows[i])
         send_request(directed_rows[i].hue, directed_rows[i].sat,
                      directed_rows[i].bright, directed_rows[i].has_known,
                      directed_rows[i].known);

      // The sender pauses until the pipeline is empty, then starts again.
      // The same pause sits between every random phase.
      drain_pipeline();

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         for (n = 0; n < PHASE_BEATS; n++) begin
            while ($urandom_range(0, 99) < idle_percent[phase])
               idle_cycle();
            send_request(random_component(), random_component(), random_component(),
                         1'b0, '0);
         end
         drain_pipeline();
      end

      // Everything has come back. Waiting on past the pipeline
      // depth catches any stray response strobe.
      idle_cycle();
      repeat (hsb2rgb_pkg::LATENCY + 4) @(posedge clock);
      if (pending_colors.size() != 0)
         report_mismatch($sformatf("%0d colors never came back", pending_colors.size()));

      $display("Run covered %0d color beats (%0d directed) and %0d responses, %0d mismatches.",
               beats_sent, DIRECTED_COUNT, colors_received, mismatch_count);
      $display("Gray beats %0d, clamped components %0d, sector hits %0d/%0d/%0d/%0d/%0d/%0d.",
               gray_beats, clamped_fields, sector_hits[0], sector_hits[1], sector_hits[2],
               sector_hits[3], sector_hits[4], sector_hits[5]);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
